### rtl/cba_pkg.sv
// Shared types and constants for the contiguous block allocator.
`timescale 1ns / 1ps

package cba_pkg;

	localparam int BLK_BYTES  = 512;
	localparam int MAX_BLOCKS = 128;
	localparam int BLK_SHIFT  = $clog2(BLK_BYTES);
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int CNT_W      = IDX_W + 1;

	localparam int SIZE_W  = 17;
	localparam int OFFS_W  = 16;
	localparam int CHG_W   = 8;
	localparam int BYTES_W = 17;
	localparam int CFG_W   = 8;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_DISABLED = 2'd1;
	localparam logic [1:0] STAT_TOO_BIG  = 2'd2;
	localparam logic [1:0] STAT_NO_RUN   = 2'd3;

	localparam logic REG_POOL_ENABLED = 1'b0;
	localparam logic REG_POOL_BLOCKS  = 1'b1;

	typedef struct packed {
		logic              opcode;
		logic [SIZE_W-1:0] size_bytes;
		logic [OFFS_W-1:0] free_offset;
	} cba_req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [OFFS_W-1:0]  buffer_offset;
		logic [CHG_W-1:0]   blocks_changed;
		logic [BYTES_W-1:0] bytes_in_use;
	} cba_rsp_t;

endpackage

### rtl/contiguous_block_allocator.sv
// Top level: first-fit contiguous block allocator over a one-bit-per-block map.
`timescale 1ns / 1ps
//
// Usage:
//   Requests: drive req and raise start; the request is taken at the clock
//   edge where start is high and busy is low. busy stays high while the
//   sequencer works on it.
//   Results: one per request, on rsp for exactly one cycle with done high.
//   The receiver cannot stall; it must take the transfer in that cycle.
//   Configuration: cfg_we, cfg_idx, cfg_wdata write pool_enabled (index 0)
//   or pool_blocks (index 1) at any edge; write only while no request is open.
// Sequencing:
//   A disabled pool or an oversize allocate answers in the cycle after accept.
//   An allocate tests one map bit per cycle from block 0, then marks the run
//   one block per cycle from its end. A free clears one block per cycle.
//   One map access per cycle sets these rates. A new request may be accepted in
//   the cycle done is high.
// Reset: arst_n clears the map, the byte count and the registers
//   (pool disabled, pool_blocks 128); no clearing pass is needed.
module contiguous_block_allocator (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  cba_pkg::cba_req_t       req,
	output logic                    done,
	output cba_pkg::cba_rsp_t       rsp,
	input  logic                    cfg_we,
	input  logic                    cfg_idx,
	input  logic [cba_pkg::CFG_W-1:0] cfg_wdata
);
	import cba_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MARK,
		ST_FREE
	} state_t;

	state_t                state_q;
	logic [MAX_BLOCKS-1:0] map_q;
	logic [BYTES_W-1:0]    used_q;
	logic                  pool_enabled_q;
	logic [CFG_W-1:0]      pool_blocks_q;
	logic [CNT_W-1:0]      idx_q;
	logic [CNT_W-1:0]      run_q;
	logic [CNT_W-1:0]      start_q;
	logic [CNT_W-1:0]      need_q;
	logic [CHG_W-1:0]      chg_q;
	logic                  done_q;
	cba_rsp_t              rsp_q;

	logic [CNT_W-1:0]      nblk;
	logic [BYTES_W-1:0]    pool_bytes;
	logic [SIZE_W:0]       size_rnd;
	logic [CNT_W-1:0]      need;
	logic                  in_pool;
	logic                  bit_used;
	logic [CNT_W-1:0]      run_nx;
	logic [CNT_W-1:0]      start_eff;
	logic                  too_big;
	logic                  found;
	logic [BYTES_W-1:0]    used_inc;

	assign nblk = (pool_blocks_q > CFG_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
		: CNT_W'(pool_blocks_q);
	assign pool_bytes = BYTES_W'(nblk) << BLK_SHIFT;
	assign size_rnd   = {1'b0, req.size_bytes} + (SIZE_W+1)'(BLK_BYTES - 1);
	assign need       = CNT_W'(size_rnd >> BLK_SHIFT);
	assign in_pool    = idx_q < nblk;
	assign bit_used   = map_q[idx_q[IDX_W-1:0]];
	assign run_nx     = run_q + CNT_W'(1);
	assign start_eff  = (run_q == '0) ? idx_q : start_q;
	assign too_big    = BYTES_W'(req.size_bytes) > pool_bytes;
	assign found      = !bit_used && (run_nx >= need_q);
	assign used_inc   = used_q + BYTES_W'(BLK_BYTES);

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			map_q          <= '0;
			used_q         <= '0;
			pool_enabled_q <= 1'b0;
			pool_blocks_q  <= CFG_W'(128);
			done_q         <= 1'b0;
			rsp_q          <= '0;
			idx_q          <= '0;
			run_q          <= '0;
			start_q        <= '0;
			need_q         <= '0;
			chg_q          <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_POOL_ENABLED: pool_enabled_q <= cfg_wdata[0];
					REG_POOL_BLOCKS:  pool_blocks_q  <= cfg_wdata;
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					done_q <= start && (!pool_enabled_q
						|| (req.opcode == OP_ALLOC && too_big));
					if (start) begin
						idx_q   <= '0;
						run_q   <= '0;
						start_q <= '0;
						chg_q   <= '0;
						need_q  <= need;
						if (!pool_enabled_q) begin
							rsp_q  <= '{STAT_DISABLED, '0, '0, used_q};
						end else if (req.opcode == OP_ALLOC) begin
							if (too_big) begin
								rsp_q  <= '{STAT_TOO_BIG, '0, '0, used_q};
							end else begin
								state_q <= ST_SCAN;
							end
						end else begin
							idx_q   <= CNT_W'(req.free_offset >> BLK_SHIFT);
							state_q <= ST_FREE;
						end
					end
				end
				ST_SCAN: begin
					done_q <= !in_pool || (found && need_q <= CNT_W'(1));
					if (!in_pool) begin
						rsp_q   <= '{STAT_NO_RUN, '0, '0, used_q};
						state_q <= ST_IDLE;
					end else if (!bit_used) begin
						start_q <= start_eff;
						run_q   <= run_nx;
						if (found) begin
							if (need_q != '0) begin
								map_q[idx_q[IDX_W-1:0]] <= 1'b1;
								used_q <= used_inc;
							end
							if (need_q > CNT_W'(1)) begin
								idx_q   <= idx_q - CNT_W'(1);
								state_q <= ST_MARK;
							end else begin
								rsp_q   <= '{STAT_OK,
									OFFS_W'(start_eff) << BLK_SHIFT,
									CHG_W'(need_q),
									(need_q != '0) ? used_inc : used_q};
								state_q <= ST_IDLE;
							end
						end else begin
							idx_q <= idx_q + CNT_W'(1);
						end
					end else begin
						run_q <= '0;
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				ST_MARK: begin
					done_q <= (idx_q == start_q);
					map_q[idx_q[IDX_W-1:0]] <= 1'b1;
					used_q <= used_inc;
					if (idx_q == start_q) begin
						rsp_q   <= '{STAT_OK,
							OFFS_W'(start_q) << BLK_SHIFT,
							CHG_W'(need_q),
							used_inc};
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q - CNT_W'(1);
					end
				end
				ST_FREE: begin
					done_q <= !(in_pool && bit_used);
					if (in_pool && bit_used) begin
						map_q[idx_q[IDX_W-1:0]] <= 1'b0;
						used_q <= used_q - BYTES_W'(BLK_BYTES);
						chg_q  <= chg_q + CHG_W'(1);
						idx_q  <= idx_q + CNT_W'(1);
					end else begin
						rsp_q   <= '{STAT_OK, '0, chg_q, used_q};
						state_q <= ST_IDLE;
					end
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_count_matches_map: assert property (@(posedge clk) disable iff (!arst_n)
		used_q == (BYTES_W'($countones(map_q)) << BLK_SHIFT))
		else $error("byte count out of step with block map");

	a_accept_progresses: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted request neither started nor answered");

	a_fail_is_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != STAT_OK) |->
		(rsp.buffer_offset == '0 && rsp.blocks_changed == '0))
		else $error("failed request reports offset or changed blocks");

	a_run_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (run_q <= idx_q && run_q < need_q + CNT_W'(1)))
		else $error("free run counter beyond scan position or need");

endmodule

### bench/tb_contiguous_block_allocator.sv
// Testbench for the contiguous block allocator: random and directed requests.
`timescale 1ns / 1ps

module tb_contiguous_block_allocator;
	import cba_pkg::*;

	typedef enum logic [1:0] {ST_REQ, ST_CFG, ST_DRAIN} step_kind_t;

	typedef struct packed {
		step_kind_t       kind;
		cba_req_t         r;
		logic             cfg_sel;
		logic [CFG_W-1:0] cfg_val;
		logic [6:0]       gap_pct;
	} step_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	cba_req_t         req = '0;
	logic             done;
	cba_rsp_t         rsp;
	logic             cfg_we = 1'b0;
	logic             cfg_idx = REG_POOL_ENABLED;
	logic [CFG_W-1:0] cfg_wdata = '0;

	step_t    plan_q[$];
	cba_rsp_t answer_q[$];
	int       n_issued = 0;
	int       n_seen = 0;
	int       n_errors = 0;
	logic [6:0] cur_gap = '0;

	// allocator model state
	bit                 used_map[MAX_BLOCKS];
	logic [BYTES_W-1:0] used_bytes = '0;
	logic               pool_en = 1'b0;
	logic [CFG_W-1:0]   pool_blk = 8'd128;

	contiguous_block_allocator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic cba_rsp_t serve_request(cba_req_t r);
		cba_rsp_t    o;
		int          nblk;
		int          need;
		int          run;
		int          first;
		int          idx;
		int          chg;
		bit          found;
		logic [31:0] tmp;
		o = '0;
		chg = 0;
		nblk = (pool_blk < MAX_BLOCKS) ? int'(pool_blk) : MAX_BLOCKS;
		if (!pool_en) begin
			o.status = STAT_DISABLED;
		end else if (r.opcode == OP_ALLOC) begin
			if (int'(r.size_bytes) > nblk * BLK_BYTES) begin
				o.status = STAT_TOO_BIG;
			end else begin
				need = (int'(r.size_bytes) + BLK_BYTES - 1) / BLK_BYTES;
				run = 0;
				first = 0;
				found = 1'b0;
				for (int i = 0; i < nblk && !found; i++) begin
					if (!used_map[i]) begin
						if (run == 0)
							first = i;
						run++;
						if (run >= need)
							found = 1'b1;
					end else begin
						run = 0;
					end
				end
				if (!found) begin
					o.status = STAT_NO_RUN;
				end else begin
					for (int i = 0; i < need; i++)
						used_map[first + i] = 1'b1;
					chg = need;
					tmp = need * BLK_BYTES;
					used_bytes = used_bytes + tmp[BYTES_W-1:0];
					tmp = first * BLK_BYTES;
					o.buffer_offset = tmp[OFFS_W-1:0];
					o.status = STAT_OK;
				end
			end
		end else begin
			o.status = STAT_OK;
			idx = int'(r.free_offset) / BLK_BYTES;
			while (idx < nblk && used_map[idx]) begin
				used_map[idx] = 1'b0;
				used_bytes = used_bytes - BYTES_W'(BLK_BYTES);
				chg++;
				idx++;
			end
		end
		tmp = chg;
		o.blocks_changed = tmp[CHG_W-1:0];
		o.bytes_in_use = used_bytes;
		return o;
	endfunction

	task automatic add_req(input logic op, input logic [31:0] size, input logic [31:0] offs);
		step_t s;
		s = '0;
		s.kind = ST_REQ;
		s.r.opcode = op;
		s.r.size_bytes = size[SIZE_W-1:0];
		s.r.free_offset = offs[OFFS_W-1:0];
		s.gap_pct = cur_gap;
		plan_q.push_back(s);
	endtask

	task automatic add_cfg(input logic sel, input logic [CFG_W-1:0] val);
		step_t s;
		s = '0;
		s.kind = ST_CFG;
		s.cfg_sel = sel;
		s.cfg_val = val;
		plan_q.push_back(s);
	endtask

	task automatic add_drain();
		step_t s;
		s = '0;
		s.kind = ST_DRAIN;
		plan_q.push_back(s);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_errors++;
		end
	endtask

	// driver: register writes and drain steps wait until no transfer is open
	always @(posedge clk or negedge arst_n) begin : drive
		step_t cur;
		logic  go;
		logic  wr;
		logic  quiet;
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
			cfg_we <= 1'b0;
			cfg_idx <= REG_POOL_ENABLED;
			cfg_wdata <= '0;
		end else begin
			go = 1'b0;
			wr = 1'b0;
			cur = '0;
			quiet = (n_issued == n_seen + int'(done)) && !busy && !start;
			if (start && !busy) begin
				answer_q.push_back(serve_request(req));
				n_issued++;
			end
			if (!(start && busy)) begin
				if (plan_q.size() != 0) begin
					cur = plan_q[0];
					case (cur.kind)
					ST_REQ: begin
						if ($urandom_range(99) >= cur.gap_pct) begin
							go = 1'b1;
							void'(plan_q.pop_front());
						end
					end
					ST_CFG: begin
						if (quiet) begin
							wr = 1'b1;
							if (cur.cfg_sel == REG_POOL_ENABLED)
								pool_en = cur.cfg_val[0];
							else
								pool_blk = cur.cfg_val;
							void'(plan_q.pop_front());
						end
					end
					default: begin
						if (quiet)
							void'(plan_q.pop_front());
					end
					endcase
				end
				start <= go;
				if (go)
					req <= cur.r;
			end
			cfg_we <= wr;
			if (wr) begin
				cfg_idx <= cur.cfg_sel;
				cfg_wdata <= cur.cfg_val;
			end
		end
	end

	// monitor
	always @(posedge clk) begin : watch
		cba_rsp_t want;
		if (arst_n && done === 1'b1) begin
			if (answer_q.size() == 0) begin
				$error("result with none pending: status %0d offset %0d", rsp.status,
					rsp.buffer_offset);
				n_errors++;
			end else begin
				want = answer_q.pop_front();
				check_field("status", 32'(want.status), 32'(rsp.status));
				check_field("buffer_offset", 32'(want.buffer_offset),
					32'(rsp.buffer_offset));
				check_field("blocks_changed", 32'(want.blocks_changed),
					32'(rsp.blocks_changed));
				check_field("bytes_in_use", 32'(want.bytes_in_use),
					32'(rsp.bytes_in_use));
			end
			n_seen <= n_seen + 1;
		end
	end

	initial begin
		int          pool_tab[8];
		int          gap_tab[8];
		int          len_tab[8];
		int          nb;
		int          hi;
		int          pick;
		logic        op;
		logic [31:0] size;
		logic [31:0] offs;
		pool_tab = '{128, 16, 255, 1, 64, 0, 3, 128};
		gap_tab = '{0, 77, 0, 36, 77, 0, 36, 0};
		len_tab = '{300, 220, 220, 150, 220, 20, 150, 370};

		// directed part
		add_req(OP_ALLOC, 512, $urandom);
		add_req(OP_FREE, $urandom, 0);
		add_cfg(REG_POOL_ENABLED, 8'h01);
		add_req(OP_ALLOC, 0, 0);
		add_req(OP_ALLOC, 1, 0);
		add_req(OP_ALLOC, 65536, 0);
		add_req(OP_ALLOC, 65537, 0);
		add_req(OP_ALLOC, 32'h1FFFF, 32'hFFFF);
		add_req(OP_ALLOC, 1024, 0);
		add_req(OP_ALLOC, 513, 0);
		add_req(OP_FREE, 0, 512);
		add_req(OP_FREE, 32'h1FFFF, 1023);
		add_req(OP_FREE, 0, 0);
		add_drain();
		add_req(OP_ALLOC, 65536, 0);
		add_req(OP_ALLOC, 0, 0);
		add_req(OP_FREE, 0, 65535);
		add_req(OP_ALLOC, 512, 0);
		add_req(OP_FREE, 0, 0);
		add_cfg(REG_POOL_BLOCKS, 8'd1);
		add_req(OP_ALLOC, 512, 0);
		add_req(OP_ALLOC, 1, 0);
		add_req(OP_ALLOC, 513, 0);
		add_cfg(REG_POOL_BLOCKS, 8'd0);
		add_req(OP_ALLOC, 0, 0);
		add_req(OP_FREE, 0, 0);
		add_cfg(REG_POOL_BLOCKS, 8'd255);
		add_req(OP_ALLOC, 4096, 0);
		add_cfg(REG_POOL_BLOCKS, 8'd4);
		add_req(OP_FREE, 0, 0);
		add_cfg(REG_POOL_BLOCKS, 8'd128);
		add_req(OP_FREE, 0, 2048);
		add_cfg(REG_POOL_ENABLED, 8'hFE);
		add_req(OP_ALLOC, 512, 0);

		// random phases
		for (int ph = 0; ph < 8; ph++) begin
			cur_gap = 7'(gap_tab[ph]);
			nb = (pool_tab[ph] < MAX_BLOCKS) ? pool_tab[ph] : MAX_BLOCKS;
			hi = (nb == 0) ? 1 : ((nb < 8) ? nb : 8);
			add_cfg(REG_POOL_BLOCKS, CFG_W'(pool_tab[ph]));
			add_cfg(REG_POOL_ENABLED, {7'($urandom), (ph != 6)});
			for (int k = 0; k < len_tab[ph]; k++) begin
				if (ph == 6 && k == 15)
					add_cfg(REG_POOL_ENABLED, {7'($urandom), 1'b1});
				pick = $urandom_range(99);
				if (pick < 50) begin
					op = OP_ALLOC;
					size = $urandom_range(hi * BLK_BYTES, 1);
					offs = $urandom;
				end else if (pick < 90) begin
					op = OP_FREE;
					size = $urandom;
					offs = $urandom_range((nb == 0) ? 0 : nb - 1) * BLK_BYTES
						+ $urandom_range(BLK_BYTES - 1);
				end else begin
					op = 1'($urandom);
					offs = $urandom;
					case ($urandom_range(3))
					0: size = 0;
					1: size = $urandom;
					2: size = nb * BLK_BYTES;
					default: size = nb * BLK_BYTES + 1;
					endcase
				end
				add_req(op, size, offs);
				if ($urandom_range(99) == 0)
					add_drain();
			end
		end

		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		while (plan_q.size() != 0 || start || n_seen != n_issued)
			@(negedge clk);
		repeat (150) @(negedge clk);
		if (answer_q.size() != 0) begin
			$error("%0d results never arrived", answer_q.size());
			n_errors++;
		end
		if (n_errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
